// ===== src/icp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// icp_pkg
// shared types and constants of the icicle pixel shader
// ----------------------------------------------------------------------------
package icp_pkg;

    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 8;
    localparam int IDX_W   = 13;
    localparam int MAG_W   = 4;
    localparam int W_W     = 9;
    localparam int T_W     = 9;

    // 1.0 in 1.8 weight format
    localparam logic [8:0]  UNITY     = 9'h100;
    localparam logic [10:0] DRIP_HALF = 11'h07F;
    localparam logic [7:0]  CHAN_MAX  = 8'hFF;

    localparam logic [COLOR_W-1:0] GROW_RESET   = 24'h4040FA;
    localparam logic [COLOR_W-1:0] RECEDE_RESET = 24'hFA80C8;
    localparam logic [COLOR_W-1:0] DRIP_RESET   = 24'h0000FF;

    typedef enum logic [1:0] {
        REG_GROW   = 2'd0,
        REG_RECEDE = 2'd1,
        REG_DRIP   = 2'd2
    } cfg_reg_t;

    // per-icicle values shared by all of its pixels
    typedef struct packed {
        logic [IDX_W-1:0] base;
        logic             odd;
        logic [2:0]       dmag;
        logic [7:0]       dfrac;
        logic             a_on;
        logic [MAG_W-1:0] a_mag;
        logic [W_W-1:0]   a_w;
        logic             b_on;
        logic [MAG_W-1:0] b_mag;
        logic [7:0]       b_w;
        logic [T_W-1:0]   t;
    } icp_item_t;

    // per-pixel control traveling with the channel values
    typedef struct packed {
        logic [IDX_W-1:0] led_index;
        logic             last;
        logic             lit;
        logic             tip;
        logic [7:0]       dfrac;
        logic [W_W-1:0]   w;
        logic [T_W-1:0]   t;
    } icp_pix_t;

endpackage
`default_nettype wire

// ===== src/icp_item_pipe.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// icp_item_pipe
// per-icicle front end: drip weights, strip base index and a pipelined
// divider for the 1.8 hold ratio
// ----------------------------------------------------------------------------
module icp_item_pipe #(
    parameter int LEDS_PER_ICICLE = 5,
    parameter int ICICLE_COUNT    = 864
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [9:0]        icicle_index,
    input  wire logic [14:0]       depth,
    input  wire logic [14:0]       hold_elapsed,
    input  wire logic [14:0]       hold_length,
    input  wire logic              receding,
    input  wire logic [14:0]       drip_position,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output icp_pkg::icp_item_t     out_item
);
    import icp_pkg::*;

    localparam int DIV_STAGES = 4;
    localparam int DIV_STEPS  = 2;
    localparam int QUOT_W     = DIV_STAGES * DIV_STEPS;
    localparam int STAGES     = DIV_STAGES + 1;

    typedef struct packed {
        logic [14:0]       hlen;
        logic [14:0]       rem;
        logic [QUOT_W-1:0] quot;
        logic              fixed;
        logic [T_W-1:0]    tfix;
    } div_state_t;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] load;
    icp_item_t         item_reg [STAGES];
    div_state_t        div_reg  [STAGES];
    icp_item_t         item0_next;
    div_state_t        div0_next;
    logic              valid0_next;
    div_state_t        div_step [DIV_STAGES];

    // a stage takes new data when empty or when its content moves on
    always_comb
    begin
        load[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    assign in_ready = load[0];

    always_comb
    begin
        logic [10:0] p;
        logic [10:0] a;
        logic [11:0] b;
        logic [31:0] base_full;

        p         = drip_position[14:4];
        a         = p - DRIP_HALF;
        b         = {1'b0, p} + {1'b0, DRIP_HALF};
        base_full = 32'(icicle_index) * 32'(LEDS_PER_ICICLE);

        item0_next       = '0;
        item0_next.base  = base_full[IDX_W-1:0];
        item0_next.odd   = icicle_index[0];
        item0_next.dmag  = depth[14:12];
        item0_next.dfrac = depth[11:4];
        if (drip_position != '0)
        begin
            item0_next.a_on = 1'b1;
            if (p > DRIP_HALF)
            begin
                // drop spans two leds
                item0_next.a_mag = {1'b0, a[10:8]};
                item0_next.a_w   = UNITY - {1'b0, a[7:0]};
                item0_next.b_on  = 1'b1;
                item0_next.b_mag = b[11:8];
                item0_next.b_w   = b[7:0];
            end
            else
            begin
                item0_next.a_w = {1'b0, p[7:0]};
            end
        end

        div0_next      = '0;
        div0_next.hlen = hold_length;
        div0_next.rem  = hold_elapsed;
        if (hold_elapsed == '0)
        begin
            // not holding: plain grow or recede color
            div0_next.fixed = 1'b1;
            div0_next.tfix  = receding ? UNITY : '0;
        end
        else if (hold_elapsed >= hold_length)
        begin
            // ratio at or above one saturates
            div0_next.fixed = 1'b1;
            div0_next.tfix  = UNITY;
        end

        valid0_next = in_valid && (32'(icicle_index) < 32'(ICICLE_COUNT));
    end

    // restoring division, DIV_STEPS quotient bits per stage
    always_comb
    begin
        logic [15:0] r2;
        div_state_t  s;

        r2 = '0;
        s  = '0;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            s = div_reg[k];
            for (int n = 0; n < DIV_STEPS; n++)
            begin
                r2 = {s.rem, 1'b0};
                if (r2 >= {1'b0, s.hlen})
                begin
                    r2     = r2 - {1'b0, s.hlen};
                    s.quot = {s.quot[QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    s.quot = {s.quot[QUOT_W-2:0], 1'b0};
                end
                s.rem = r2[14:0];
            end
            div_step[k] = s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                valid_reg[0] <= valid0_next;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (load[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            item_reg[0] <= item0_next;
            div_reg[0]  <= div0_next;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            if (load[k])
            begin
                item_reg[k] <= item_reg[k-1];
                div_reg[k]  <= div_step[k-1];
            end
        end
    end

    always_comb
    begin
        out_item   = item_reg[STAGES-1];
        out_item.t = div_reg[STAGES-1].fixed ? div_reg[STAGES-1].tfix
                                             : {1'b0, div_reg[STAGES-1].quot};
    end

    assign out_valid = valid_reg[STAGES-1];

endmodule
`default_nettype wire

// ===== src/icp_pixel_pipe.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// icp_pixel_pipe
// three-stage color datapath: hold cross-fade, tip scaling, drip blend with
// saturation into the output register
// ----------------------------------------------------------------------------
module icp_pixel_pipe (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire icp_pkg::icp_pix_t          in_pix,
    input  wire logic [icp_pkg::COLOR_W-1:0] grow_color,
    input  wire logic [icp_pkg::COLOR_W-1:0] recede_color,
    input  wire logic [icp_pkg::COLOR_W-1:0] drip_color,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [icp_pkg::IDX_W-1:0]       led_index,
    output logic [7:0]                      red,
    output logic [7:0]                      green,
    output logic [7:0]                      blue,
    output logic                            last_pixel
);
    import icp_pkg::*;

    localparam int NCH = 3;

    function automatic logic [CHAN_W-1:0] chan_of(input logic [COLOR_W-1:0] color,
                                                  input int c);
        chan_of = color[COLOR_W-1-CHAN_W*c -: CHAN_W];
    endfunction

    logic [2:0]        valid_reg;
    logic [2:0]        load;
    icp_pix_t          pix1_reg;
    icp_pix_t          pix2_reg;
    icp_pix_t          pix3_reg;
    logic [15:0]       chan1_reg [NCH];
    logic [15:0]       chan2_reg [NCH];
    logic [CHAN_W-1:0] chan3_reg [NCH];
    logic [15:0]       chan1_next [NCH];
    logic [15:0]       chan2_next [NCH];
    logic [CHAN_W-1:0] chan3_next [NCH];

    always_comb
    begin
        load[2] = !valid_reg[2] || out_ready;
        load[1] = !valid_reg[1] || load[2];
        load[0] = !valid_reg[0] || load[1];
    end

    assign in_ready = load[0];

    // cross-fade: grow * (1 - t) + recede * t
    always_comb
    begin
        logic [16:0] mg;
        logic [16:0] mr;
        logic [16:0] sum;

        mg  = '0;
        mr  = '0;
        sum = '0;
        for (int c = 0; c < NCH; c++)
        begin
            mg  = 17'(chan_of(grow_color, c)) * 17'(UNITY - in_pix.t);
            mr  = 17'(chan_of(recede_color, c)) * 17'(in_pix.t);
            sum = mg + mr;
            chan1_next[c] = sum[15:0];
        end
    end

    // bottom led scaled by the depth fraction, unlit leds black
    always_comb
    begin
        logic [23:0] prod;

        prod = '0;
        for (int c = 0; c < NCH; c++)
        begin
            prod = 24'(chan1_reg[c]) * 24'(pix1_reg.dfrac);
            if (!pix1_reg.lit)
            begin
                chan2_next[c] = '0;
            end
            else if (pix1_reg.tip)
            begin
                chan2_next[c] = prod[23:8];
            end
            else
            begin
                chan2_next[c] = chan1_reg[c];
            end
        end
    end

    // drip blend, then saturate and keep the top byte
    always_comb
    begin
        logic [24:0] keep;
        logic [16:0] dw;
        logic [16:0] total;

        keep  = '0;
        dw    = '0;
        total = '0;
        for (int c = 0; c < NCH; c++)
        begin
            keep  = 25'(chan2_reg[c]) * 25'(UNITY - pix2_reg.w);
            dw    = 17'(chan_of(drip_color, c)) * 17'(pix2_reg.w);
            total = 17'(keep[23:8]) + dw;
            chan3_next[c] = total[16] ? CHAN_MAX : total[15:8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                valid_reg[0] <= in_valid;
            end
            if (load[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
            if (load[2])
            begin
                valid_reg[2] <= valid_reg[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            pix1_reg  <= in_pix;
            chan1_reg <= chan1_next;
        end
        if (load[1])
        begin
            pix2_reg  <= pix1_reg;
            chan2_reg <= chan2_next;
        end
        if (load[2])
        begin
            pix3_reg  <= pix2_reg;
            chan3_reg <= chan3_next;
        end
    end

    assign out_valid  = valid_reg[2];
    assign led_index  = pix3_reg.led_index;
    assign last_pixel = pix3_reg.last;
    assign red        = chan3_reg[0];
    assign green      = chan3_reg[1];
    assign blue       = chan3_reg[2];

endmodule
`default_nettype wire

// ===== src/icicle_pixel_shader.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// icicle_pixel_shader
// turns the state of one led icicle into one rgb pixel per led
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one request per icicle (index, depth, hold timing, direction,
//           drip position); icicles at or beyond ICICLE_COUNT are taken and
//           dropped without any pixel
//   out_* : LEDS_PER_ICICLE pixel requests per icicle, in led order, each
//           with its strip index; last_pixel marks the final one
//   cfg_* : writes grow, recede and drip colors by register index; always
//           ready, write only while no icicle is in flight
// path: the first pixel passes the input register, four divider stages,
//   the serializer and three color stages before it is valid
// throughput: one pixel per cycle while the output is not held; the
//   serializer sends the pixels one by one and takes the next icicle as it sends the last
// reset: pipelines empty, colors return to their reset values
// stall: a held output freezes the pixel stages behind it; bubbles are
//   squeezed out and the front end keeps taking icicles until it is full
// ----------------------------------------------------------------------------
module icicle_pixel_shader #(
    parameter int LEDS_PER_ICICLE = 5,
    parameter int ICICLE_COUNT    = 864
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [9:0]                  icicle_index,
    input  wire logic [14:0]                 depth,
    input  wire logic [14:0]                 hold_elapsed,
    input  wire logic [14:0]                 hold_length,
    input  wire logic                        receding,
    input  wire logic [14:0]                 drip_position,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [icp_pkg::IDX_W-1:0]        led_index,
    output logic [7:0]                       red,
    output logic [7:0]                       green,
    output logic [7:0]                       blue,
    output logic                             last_pixel,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [icp_pkg::COLOR_W-1:0] cfg_data
);
    import icp_pkg::*;

    localparam int JW = $clog2(LEDS_PER_ICICLE);
    localparam logic [JW-1:0] J_LAST = JW'(LEDS_PER_ICICLE - 1);

    logic [COLOR_W-1:0] grow_reg;
    logic [COLOR_W-1:0] recede_reg;
    logic [COLOR_W-1:0] drip_reg;

    logic      item_out_valid;
    logic      item_out_ready;
    icp_item_t item_out;

    logic      ser_valid_reg;
    logic      ser_valid_next;
    icp_item_t ser_item_reg;
    logic [JW-1:0] j_reg;
    logic [JW-1:0] j_next;
    logic      ser_fire;
    logic      ser_done;
    logic      item_load;
    logic      pix_ready;
    icp_pix_t  pix;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grow_reg   <= GROW_RESET;
            recede_reg <= RECEDE_RESET;
            drip_reg   <= DRIP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GROW:   grow_reg   <= cfg_data;
                REG_RECEDE: recede_reg <= cfg_data;
                REG_DRIP:   drip_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    icp_item_pipe #(
        .LEDS_PER_ICICLE (LEDS_PER_ICICLE),
        .ICICLE_COUNT    (ICICLE_COUNT)
    ) u_item (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .icicle_index  (icicle_index),
        .depth         (depth),
        .hold_elapsed  (hold_elapsed),
        .hold_length   (hold_length),
        .receding      (receding),
        .drip_position (drip_position),
        .out_valid     (item_out_valid),
        .out_ready     (item_out_ready),
        .out_item      (item_out)
    );

    // serializer: one pixel per cycle from the held icicle while the pixel pipe is ready
    assign ser_fire       = ser_valid_reg && pix_ready;
    assign ser_done       = ser_fire && (j_reg == J_LAST);
    assign item_load      = !ser_valid_reg || ser_done;
    assign item_out_ready = item_load;

    always_comb
    begin
        ser_valid_next = ser_valid_reg;
        j_next         = j_reg;
        if (item_load)
        begin
            ser_valid_next = item_out_valid;
            j_next         = '0;
        end
        else if (ser_fire)
        begin
            j_next = j_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            j_reg         <= '0;
        end
        else
        begin
            ser_valid_reg <= ser_valid_next;
            j_reg         <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_load && item_out_valid)
        begin
            ser_item_reg <= item_out;
        end
    end

    always_comb
    begin
        logic [JW-1:0]    jj;
        logic [MAG_W-1:0] jm;

        // odd icicles are wired bottom first
        jj = ser_item_reg.odd ? (J_LAST - j_reg) : j_reg;
        jm = MAG_W'(j_reg);

        pix           = '0;
        pix.led_index = ser_item_reg.base + IDX_W'(jj);
        pix.last      = (j_reg == J_LAST);
        pix.lit       = (jm <= {1'b0, ser_item_reg.dmag});
        pix.tip       = (jm == {1'b0, ser_item_reg.dmag});
        pix.dfrac     = ser_item_reg.dfrac;
        pix.t         = ser_item_reg.t;
        if (pix.lit)
        begin
            if (ser_item_reg.a_on && (jm == ser_item_reg.a_mag))
            begin
                pix.w = ser_item_reg.a_w;
            end
            else if (ser_item_reg.b_on && (jm == ser_item_reg.b_mag))
            begin
                pix.w = {1'b0, ser_item_reg.b_w};
            end
        end
    end

    icp_pixel_pipe u_pixel (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (ser_valid_reg),
        .in_ready     (pix_ready),
        .in_pix       (pix),
        .grow_color   (grow_reg),
        .recede_color (recede_reg),
        .drip_color   (drip_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .led_index    (led_index),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .last_pixel   (last_pixel)
    );

    // serializer empties after the last pixel when no icicle is waiting
    a_ser_drain: assert property (@(posedge clk) disable iff (!rst_n)
        ser_done && !item_out_valid |=> !ser_valid_reg)
        else $error("serializer still busy after last pixel");

    // a newly loaded icicle always starts at its first led
    a_j_restart: assert property (@(posedge clk) disable iff (!rst_n)
        item_load && item_out_valid |=> ser_valid_reg && (j_reg == '0))
        else $error("led counter not restarted on new icicle");

    // a grow color write lands in its register
    a_cfg_grow: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && (cfg_index == 2'(REG_GROW))
        |=> grow_reg == $past(cfg_data))
        else $error("grow color write lost");

endmodule
`default_nettype wire
